// ----- hw/rtl/pwte_pkg.sv -----
// Package for the pulse width threshold estimator.
// Holds table size, field widths, scan constants and controller/datapath structs.
// No dependencies.
`default_nettype none

package pwte_pkg;

   localparam int NUM_BINS = 256;
   localparam int BIN_W    = $clog2(NUM_BINS);
   localparam int CNT_W    = BIN_W + 1;

   localparam int PW_W    = 32;
   localparam int CAP_W   = 8;
   localparam int THR_W   = 9;
   localparam int MAXW_W  = 8;
   localparam int DCNT_W  = 9;

   localparam logic [CAP_W-1:0] CAP_RESET       = CAP_W'(30);
   localparam logic [THR_W-1:0] EMPTY_THRESHOLD = THR_W'(3);

   // floor(3n/10) as (n * 615) >> 11, exact while 3n < 1029
   localparam int DIV_MUL   = 615;
   localparam int DIV_SHIFT = 11;
   localparam int PROD_W    = CNT_W + 10;

   typedef struct packed {
      logic wipe;
      logic count;
      logic scan_init;
      logic scan_step;
      logic load_out;
      logic clear;
   } pwte_cmd_type;

   typedef struct packed {
      logic scan_last;
   } pwte_status_type;

endpackage

`default_nettype wire

// ----- hw/rtl/pwte_if.sv -----
// Handshake channels of the pulse width threshold estimator.
// Depends on pwte_pkg for field widths.
`default_nettype none

interface pwte_req_if
   import pwte_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [PW_W-1:0]   pulse_width;
   logic              last;

   modport source (output valid, output pulse_width, output last, input ready);
   modport sink   (input valid, input pulse_width, input last, output ready);
endinterface

interface pwte_rsp_if
   import pwte_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [THR_W-1:0]  threshold;
   logic [MAXW_W-1:0] widest;
   logic [DCNT_W-1:0] distinct_count;

   modport source (output valid, output threshold, output widest,
                   output distinct_count, input ready);
   modport sink   (input valid, input threshold, input widest,
                   input distinct_count, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/pwte_ctrl.sv -----
// Controller of the pulse width threshold estimator: table wipe, idle, bin scan, result load.
// Depends on pwte_pkg for the command and status structs.
`default_nettype none

module pwte_ctrl
   import pwte_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            req_last,
   output logic                 req_ready,
   input  wire logic            rsp_ready,
   output logic                 rsp_valid,
   input  wire pwte_status_type status,
   output pwte_cmd_type         cmd
);

   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      cmd           = '0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.wipe = 1'b1;
            if (status.scan_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd.count = 1'b1;
               if (req_last) begin
                  cmd.scan_init = 1'b1;
                  state_in      = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               cmd.clear    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/pwte_datapath.sv -----
// Datapath of the pulse width threshold estimator: presence table, running maximum,
// gap scan registers and result registers. Depends on pwte_pkg.
`default_nettype none

module pwte_datapath
   import pwte_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write_enable,
   input  wire logic [CAP_W-1:0]  csr_write_data,
   input  wire logic [PW_W-1:0]   req_pulse_width,
   input  wire pwte_cmd_type      cmd,
   output pwte_status_type        status,
   output logic [THR_W-1:0]       rsp_threshold,
   output logic [MAXW_W-1:0]      rsp_widest,
   output logic [DCNT_W-1:0]      rsp_distinct_count
);

   logic [CAP_W-1:0]    width_cap_ff;
   logic                seen_mem [NUM_BINS];
   logic                seen_rd_ff;
   logic                rd_valid_ff;
   logic [BIN_W-1:0]    rd_idx_ff;
   logic [MAXW_W-1:0]   largest_ff;

   logic [BIN_W-1:0]    idx_ff, idx_in;
   logic [BIN_W-1:0]    prev_ff, prev_in;
   logic [BIN_W-1:0]    first_ff, first_in;
   logic [BIN_W-1:0]    max_gap_ff, max_gap_in;
   logic [BIN_W-1:0]    split_ff, split_in;
   logic [CNT_W-1:0]    n_ff, n_in;

   logic [THR_W-1:0]    thr_ff;
   logic [MAXW_W-1:0]   max_out_ff;
   logic [DCNT_W-1:0]   dcnt_ff;

   logic [BIN_W-1:0]    w_idx;
   logic                w_ok;
   logic [BIN_W-1:0]    gap;
   logic [PROD_W-1:0]   prod;
   logic [CNT_W-1:0]    frac;
   logic [CNT_W-1:0]    thr_sel;

   // drop zero, capped and oversized widths
   assign w_idx = req_pulse_width[BIN_W-1:0];
   assign w_ok  = (req_pulse_width != '0)
               && !(width_cap_ff != '0 && req_pulse_width > PW_W'(width_cap_ff))
               && (req_pulse_width < PW_W'(NUM_BINS));

   assign status.scan_last = (idx_ff == BIN_W'(NUM_BINS - 1));
   assign gap              = rd_idx_ff - prev_ff;

   always_comb begin
      idx_in     = idx_ff;
      prev_in    = prev_ff;
      first_in   = first_ff;
      max_gap_in = max_gap_ff;
      split_in   = split_ff;
      n_in       = n_ff;
      if (cmd.scan_init) begin
         idx_in     = BIN_W'(1);
         prev_in    = '0;
         first_in   = '0;
         max_gap_in = '0;
         split_in   = '0;
         n_in       = '0;
      end else begin
         if (cmd.scan_step || cmd.wipe) begin
            idx_in = idx_ff + BIN_W'(1);
         end
         if (rd_valid_ff && seen_rd_ff) begin
            if (n_ff == '0) begin
               first_in = rd_idx_ff;
               split_in = rd_idx_ff;
            end else if (gap > max_gap_ff) begin
               max_gap_in = gap;
               split_in   = prev_ff;
            end
            prev_in = rd_idx_ff;
            n_in    = n_ff + CNT_W'(1);
         end
      end
   end

   assign prod = PROD_W'(n_ff) * PROD_W'(DIV_MUL);
   assign frac = CNT_W'(prod >> DIV_SHIFT);

   always_comb begin
      priority if (n_ff == '0) begin
         thr_sel = CNT_W'(EMPTY_THRESHOLD);
      end else if (n_ff == CNT_W'(1)) begin
         thr_sel = CNT_W'(first_ff) + CNT_W'(1);
      end else if (max_gap_ff <= BIN_W'(1)) begin
         thr_sel = CNT_W'(first_ff) + frac + CNT_W'(1);
      end else begin
         thr_sel = CNT_W'(split_ff) + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_cap_ff <= CAP_RESET;
      end else if (csr_write_enable) begin
         width_cap_ff <= csr_write_data;
      end
   end

   // clear each bin as the wipe or the scan passes it
   always_ff @(posedge clock) begin
      if (cmd.wipe || cmd.scan_step) begin
         seen_mem[idx_ff] <= 1'b0;
      end else if (cmd.count && w_ok) begin
         seen_mem[w_idx] <= 1'b1;
      end
      seen_rd_ff <= seen_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         largest_ff <= '0;
      end else if (cmd.count && w_ok) begin
         if (req_pulse_width > PW_W'(largest_ff)) begin
            largest_ff <= MAXW_W'(w_idx);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         idx_ff      <= idx_in;
         rd_valid_ff <= cmd.scan_step;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff  <= idx_ff;
      prev_ff    <= prev_in;
      first_ff   <= first_in;
      max_gap_ff <= max_gap_in;
      split_ff   <= split_in;
      n_ff       <= n_in;
      if (cmd.load_out) begin
         thr_ff     <= THR_W'(thr_sel);
         max_out_ff <= largest_ff;
         dcnt_ff    <= DCNT_W'(n_ff);
      end
   end

   assign rsp_threshold      = thr_ff;
   assign rsp_widest         = max_out_ff;
   assign rsp_distinct_count = dcnt_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/pulse_width_threshold_estimator.sv -----
// Top level of the pulse width threshold estimator.
// Depends on pwte_pkg, pwte_if, pwte_ctrl and pwte_datapath.
//
//   port       dir   word
//   req_word   in    pulse_width[31:0], last
//   rsp_word   out   threshold[8:0], widest[7:0], distinct_count[8:0]
//   csr_*      in    width_cap[7:0], written when csr_write_enable is high
//
// After reset a clearing pass wipes the presence table, one bin per cycle, with req_ready
// low throughout. Reset also sets width_cap to 30.
// A word without last is accepted whenever the block is idle, back to back.
// A word with last starts a scan of bins 1 to NUM_BINS - 1, one per cycle, clearing each
// bin as it is read; a drain state and the load state follow, with req_ready low until the load.
// The result register holds until taken; the load waits while it is still full.
`default_nettype none

module pulse_width_threshold_estimator
   import pwte_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   pwte_req_if.sink              req_word,
   pwte_rsp_if.source            rsp_word,
   input  wire logic             csr_write_enable,
   input  wire logic [CAP_W-1:0] csr_write_data
);

   pwte_cmd_type    cmd;
   pwte_status_type status;

   pwte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_word.valid),
      .req_last  (req_word.last),
      .req_ready (req_word.ready),
      .rsp_ready (rsp_word.ready),
      .rsp_valid (rsp_word.valid),
      .status    (status),
      .cmd       (cmd)
   );

   pwte_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_pulse_width    (req_word.pulse_width),
      .cmd                (cmd),
      .status             (status),
      .rsp_threshold      (rsp_word.threshold),
      .rsp_widest         (rsp_word.widest),
      .rsp_distinct_count (rsp_word.distinct_count)
   );

endmodule

`default_nettype wire
